// ----- src/dmpt_pkg.sv -----
// shared types and constants for the direct-mapped position table
package dmpt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SIZE_W      = 11;
   localparam int KEY_W       = 64;
   localparam int VALUE_W     = 32;
   localparam int DEPTH_W     = 9;
   localparam int MOVE_W      = 13;
   localparam int DIVD_W      = 28;
   localparam int DIV_CNT_W   = 5;
   localparam int REQ_DATA_W  = 120;
   localparam int RSP_DATA_W  = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

   localparam logic [1:0] OP_STORE    = 2'd0;
   localparam logic [1:0] OP_OPEN_ADD = 2'd1;
   localparam logic [1:0] OP_FIND     = 2'd2;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [DEPTH_W-1:0] depth;
      logic [MOVE_W-1:0]  move;
   } dmpt_entry_type;

   localparam int ENTRY_W = $bits(dmpt_entry_type);

   typedef struct packed {
      logic clear;
      logic load;
      logic div_step;
      logic rd;
      logic exec;
   } dmpt_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_last;
   } dmpt_status_type;

endpackage

// ----- src/dmpt_ram.sv -----
// generic simple dual-port ram with registered read
module dmpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dmpt_ctrl.sv -----
// sequencer for the position table: clear pass, slot divide, read, update
module dmpt_ctrl import dmpt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  dmpt_status_type status,
   output dmpt_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: cmd.clear    = 1'b1;
         ST_IDLE:  cmd.load     = req_tvalid;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_READ:  cmd.rd       = 1'b1;
         // update only once the output register is free
         ST_EXEC:  cmd.exec     = !rsp_valid_ff || rsp_tready;
         default:  cmd          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_EXEC;
            ST_EXEC: begin
               if (cmd.exec) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase

         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- src/dmpt_dp.sv -----
// datapath: request registers, slot remainder unit, table ram and result registers
module dmpt_dp import dmpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data,
   input  logic [1:0]            req_op,
   input  logic [REQ_DATA_W-1:0] req_data,
   input  dmpt_cmd_type          cmd,
   output dmpt_status_type       status,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   logic [SIZE_W-1:0]    size_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [1:0]           op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_W-1:0]   score_ff;
   logic [DEPTH_W-1:0]   depth_ff;
   logic [MOVE_W-1:0]    move_ff;
   logic [DIVD_W-1:0]    dvd_ff;
   logic [ADDR_W-1:0]    rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 hit_ff;
   logic                 km_ff;
   logic [VALUE_W-1:0]   val_ff;

   logic [31:0]          size_wide;
   logic [31:0]          eff_wide;
   logic [ADDR_W:0]      eff_n;
   logic [ADDR_W:0]      trial;
   logic [ADDR_W-1:0]    rem_in;

   dmpt_entry_type       rd_entry;
   dmpt_entry_type       new_entry;
   logic [ENTRY_W-1:0]   rd_word;
   logic                 match;
   logic                 wr_need;
   logic                 hit_in;
   logic                 km_in;
   logic [VALUE_W-1:0]   val_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;

   // size 0 acts as 1, sizes above the table depth saturate
   always_comb begin
      size_wide = 32'(size_ff);
      if (size_ff == '0) begin
         eff_wide = 32'd1;
      end else if (size_wide > 32'(TABLE_DEPTH)) begin
         eff_wide = 32'(TABLE_DEPTH);
      end else begin
         eff_wide = size_wide;
      end
      eff_n = eff_wide[ADDR_W:0];
   end

   // one restoring step per cycle, msb of the key slice first
   always_comb begin
      trial = {rem_ff, dvd_ff[DIVD_W-1]};
      if (trial >= eff_n) begin
         rem_in = ADDR_W'(trial - eff_n);
      end else begin
         rem_in = trial[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         clr_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         key_ff   <= req_data[63:0];
         score_ff <= req_data[95:64];
         depth_ff <= req_data[104:96];
         move_ff  <= req_data[117:105];
         dvd_ff   <= req_data[DIVD_W-1:0];
         rem_ff   <= '0;
         cnt_ff   <= DIV_CNT_W'(DIVD_W - 1);
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DIVD_W-2:0], 1'b0};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.exec) begin
         hit_ff <= hit_in;
         km_ff  <= km_in;
         val_ff <= val_in;
      end
   end

   assign status.clear_last = (clr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign status.div_last   = (cnt_ff == '0);

   assign rd_entry = dmpt_entry_type'(rd_word);
   assign match    = rd_entry.valid && (rd_entry.key == key_ff);

   always_comb begin
      new_entry = '{valid: 1'b1, key: key_ff, value: score_ff,
                    depth: depth_ff, move: move_ff};
      wr_need   = 1'b0;
      hit_in    = 1'b0;
      km_in     = 1'b0;
      val_in    = '0;
      case (op_ff)
         OP_STORE: begin
            km_in   = match;
            wr_need = 1'b1;
         end
         OP_OPEN_ADD: begin
            km_in   = match;
            wr_need = 1'b1;
            if (match) begin
               new_entry       = rd_entry;
               new_entry.value = rd_entry.value + score_ff;
            end else begin
               // opening entry: depth and move both all ones
               new_entry.depth = '1;
               new_entry.move  = '1;
            end
         end
         OP_FIND: begin
            km_in = match;
            if (match) begin
               val_in = rd_entry.value;
               hit_in = (rd_entry.move == '1) ||
                        ((rd_entry.depth == depth_ff) && (rd_entry.move == move_ff));
            end
         end
         default: begin
            wr_need = 1'b0;
         end
      endcase
   end

   assign ram_we    = cmd.clear || (cmd.exec && wr_need);
   assign ram_waddr = cmd.clear ? clr_ff : rem_ff;
   assign ram_wdata = cmd.clear ? '0 : ENTRY_W'(new_entry);

   dmpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd),
      .rd_addr (rem_ff),
      .rd_data (rd_word)
   );

   assign rsp_data = {6'd0, val_ff, km_ff, hit_ff};

endmodule

// ----- src/direct_mapped_position_table.sv -----
// top level of the direct-mapped position table
//
// Requests arrive on req_*: op in req_tuser, key, score, depth and move count
// packed in req_tdata. Each request gives exactly one response on rsp_*:
// hit, key match and found value packed in rsp_tdata. The user writes table_size
// through csr_wr_en / csr_wr_data only while no request is in flight; the block
// does not enforce this. The slot is the low 28 key bits modulo the effective
// table size, worked out by a remainder unit that retires one key bit per cycle.
// A request then takes a table read step and an update step before its response
// is registered, and a new request is taken only once that update is done.
// After reset the block sweeps all 1024 slots to clear their valid bits,
// one per cycle, and holds req_tready low until the sweep ends; the
// configuration port works throughout. Reset also returns table_size to 1024.
// The response sits in an output register: the next request is taken while
// it waits, and a stalled receiver blocks only the update step of the
// following request until the register is free.
module direct_mapped_position_table import dmpt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data,   // table_size
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key [63:0], score [95:64], depth [104:96], move_count [117:105], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,     // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit [0], key_match [1], found_value [33:2], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   dmpt_cmd_type    cmd;
   dmpt_status_type status;

   dmpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dmpt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_op      (req_tuser),
      .req_data    (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_tdata)
   );

endmodule

// ----- src/dmpt_chk.sv -----
// port checker for the position table, bound to the top level
module dmpt_chk import dmpt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   a_hit_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("hit without key match");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[33:2] == '0)
      else $error("nonzero value without key match");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block not idle in clear pass after reset");

endmodule

bind direct_mapped_position_table dmpt_chk u_dmpt_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/testbench.sv -----
// self-checking testbench for the direct-mapped position table
module testbench;
   import dmpt_pkg::*;

   localparam int          HALF_PERIOD      = 6;
   localparam int          WATCHDOG_LIMIT   = 6000;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          POOL_SIZE        = 16;
   localparam int          PHASE_REQUESTS   = 460;
   localparam logic [1:0]  OP_UNUSED        = 2'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_OPENING = '1;
   localparam logic [MOVE_W-1:0]  MOVE_OPENING  = '1;

   typedef struct packed {
      logic [1:0]         op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] score;
      logic [DEPTH_W-1:0] depth;
      logic [MOVE_W-1:0]  move;
   } probe_type;

   typedef struct packed {
      logic               hit;
      logic               key_match;
      logic [VALUE_W-1:0] value;
   } probe_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [SIZE_W-1:0]     csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the table
   logic [SIZE_W-1:0]  shadow_size;
   bit                 shadow_valid [TABLE_DEPTH];
   logic [KEY_W-1:0]   shadow_key   [TABLE_DEPTH];
   logic [VALUE_W-1:0] shadow_value [TABLE_DEPTH];
   logic [DEPTH_W-1:0] shadow_depth [TABLE_DEPTH];
   logic [MOVE_W-1:0]  shadow_move  [TABLE_DEPTH];

   probe_result_type pending_results [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int  mismatch_count    = 0;
   int  requests_taken    = 0;
   int  responses_checked = 0;
   int  finds_hit         = 0;
   int  stall_cycles      = 0;
   int  send_idle_pct     = 0;
   int  rsp_stall_pct     = 0;
   bit  hold_pending      = 1'b0;

   direct_mapped_position_table u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned slot_of_key(logic [KEY_W-1:0] key);
      int unsigned n;
      n = shadow_size;
      if (n == 0) n = 1;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return key[DIVD_W-1:0] % n;
   endfunction

   task automatic predict_probe(input probe_type p);
      int unsigned      s;
      logic             key_hit;
      probe_result_type r;
      s = slot_of_key(p.key);
      key_hit = shadow_valid[s] && (shadow_key[s] == p.key);
      r = '0;
      case (p.op)
         OP_STORE: begin
            r.key_match     = key_hit;
            shadow_valid[s] = 1'b1;
            shadow_key[s]   = p.key;
            shadow_value[s] = p.score;
            shadow_depth[s] = p.depth;
            shadow_move[s]  = p.move;
         end
         OP_OPEN_ADD: begin
            r.key_match = key_hit;
            if (key_hit) begin
               shadow_value[s] = shadow_value[s] + p.score;
            end else begin
               shadow_valid[s] = 1'b1;
               shadow_key[s]   = p.key;
               shadow_value[s] = p.score;
               shadow_depth[s] = DEPTH_OPENING;
               shadow_move[s]  = MOVE_OPENING;
            end
         end
         OP_FIND: begin
            r.key_match = key_hit;
            if (key_hit) begin
               r.value = shadow_value[s];
               // opening entries hit regardless of depth and move
               r.hit = (shadow_move[s] == MOVE_OPENING) ||
                       (shadow_depth[s] == p.depth && shadow_move[s] == p.move);
            end
         end
         default: ;
      endcase
      if (r.hit) finds_hit++;
      pending_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 50)
         $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // response check and request prediction, both sampled at the rising edge
   always @(posedge clock) begin : check_and_predict
      probe_result_type want;
      probe_type        taken;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_tdata, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[0] !== want.hit)
                  report_mismatch("hit", rsp_tdata[0], want.hit);
               if (rsp_tdata[1] !== want.key_match)
                  report_mismatch("key_match", rsp_tdata[1], want.key_match);
               if (rsp_tdata[33:2] !== want.value)
                  report_mismatch("found_value", rsp_tdata[33:2], want.value);
               responses_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            taken.op    = req_tuser;
            taken.key   = req_tdata[63:0];
            taken.score = req_tdata[95:64];
            taken.depth = req_tdata[104:96];
            taken.move  = req_tdata[117:105];
            predict_probe(taken);
            requests_taken++;
         end
      end
   end

   // receiver: random stalls, plus one long hold when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // covers the clearing sweep after reset and the long receiver hold
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // returns at the accepting edge unless an idle gap follows
   task automatic send_request(input probe_type p);
      @(negedge clock);
      req_tuser  <= p.op;
      req_tdata  <= {2'b00, p.move, p.depth, p.score, p.key};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(39)) @(negedge clock);
      end
   endtask

   task automatic wait_all_returned();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [SIZE_W-1:0] size);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      shadow_size = size;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic refresh_key_pool();
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
   endtask

   function automatic probe_type random_probe();
      probe_type   p;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35)      p.op = OP_STORE;
      else if (pick < 60) p.op = OP_OPEN_ADD;
      else if (pick < 96) p.op = OP_FIND;
      else                p.op = OP_UNUSED;
      p.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                        : {$urandom, $urandom};
      if ($urandom_range(9) == 0)
         p.score = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      else
         p.score = $urandom;
      // small depth and move sets so finds line up with stored entries
      pick = $urandom_range(9);
      if (pick < 6)      p.depth = DEPTH_W'($urandom_range(3));
      else if (pick < 8) p.depth = DEPTH_OPENING;
      else               p.depth = DEPTH_W'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick < 6)      p.move = MOVE_W'($urandom_range(3));
      else if (pick < 8) p.move = MOVE_OPENING;
      else               p.move = MOVE_W'($urandom_range(4095));
      return p;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_request(random_probe());
      wait_all_returned();
   endtask

   task automatic test_directed();
      logic [KEY_W-1:0] ones;
      ones = '1;
      send_request('{OP_FIND,     64'h0, 32'h0,         9'd0,   13'd0});
      send_request('{OP_STORE,    64'h0, 32'h7fff_ffff, 9'd255, 13'd4095});
      send_request('{OP_FIND,     64'h0, 32'h0,         9'd255, 13'd4095});
      send_request('{OP_FIND,     64'h0, 32'h0,         9'd0,   13'd4095});
      send_request('{OP_FIND,     64'h0, 32'h0,         9'd255, 13'd0});
      // add wraps past the largest positive value
      send_request('{OP_OPEN_ADD, 64'h0, 32'h1,         9'd7,   13'd9});
      send_request('{OP_FIND,     64'h0, 32'h0,         9'd255, 13'd4095});
      send_request('{OP_OPEN_ADD, ones,  32'h8000_0000, 9'd3,   13'd3});
      send_request('{OP_FIND,     ones,  32'h0,         9'd100, 13'd200});
      send_request('{OP_OPEN_ADD, ones,  32'hffff_ffff, 9'd0,   13'd0});
      send_request('{OP_FIND,     ones,  32'h0,         9'd0,   13'd0});
      // a store with move -1 also marks an opening entry
      send_request('{OP_STORE,    64'h1234_5678_0000_0005, 32'h55, DEPTH_OPENING, MOVE_OPENING});
      send_request('{OP_FIND,     64'h1234_5678_0000_0005, 32'h0,  9'd17, 13'd33});
      send_request('{OP_UNUSED,   ones,  32'hffff_ffff, DEPTH_OPENING, MOVE_OPENING});
      send_request('{OP_FIND,     64'h1234_5678_0000_0005, 32'h0,  9'd0,  13'd0});
      // same slot as key 0 with different upper bits evicts it
      send_request('{OP_STORE,    64'h8000_0000_0000_0000, 32'hffff_ffff, 9'd0, 13'd0});
      send_request('{OP_FIND,     64'h0, 32'h0,         9'd0,   13'd0});
      send_request('{OP_FIND,     64'h8000_0000_0000_0000, 32'h0, 9'd0, 13'd0});
      send_request('{OP_OPEN_ADD, 64'h8000_0000_0000_0000, 32'h8000_0000, 9'd0, 13'd0});
      send_request('{OP_FIND,     64'h8000_0000_0000_0000, 32'h0, 9'd0, 13'd0});
      wait_all_returned();
   endtask

   task automatic test_table_sizes();
      logic [SIZE_W-1:0] sizes [7];
      sizes = '{11'd0, 11'd1, 11'd2047, 11'd1025, 11'd2, 11'd1024, 11'd3};
      refresh_key_pool();
      foreach (sizes[i]) begin
         set_table_size(sizes[i]);
         run_random(16);
      end
   endtask

   task automatic test_random_phases();
      int idle_mode [4][2];
      idle_mode = '{'{0, 0}, '{45, 0}, '{0, 45}, '{10, 10}};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_mode[ph][0];
         rsp_stall_pct = idle_mode[ph][1];
         refresh_key_pool();
         case (ph)
            0: set_table_size(11'd1024);
            1: set_table_size(SIZE_W'($urandom_range(1, 16)));
            2: set_table_size(SIZE_W'($urandom_range(1, 2047)));
            default: set_table_size(11'd37);
         endcase
         run_random(PHASE_REQUESTS);
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      set_table_size(11'd8);
      hold_pending = 1'b1;
      run_random(10);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      shadow_size = SIZE_RESET;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_sizes();
      test_random_phases();
      test_backpressure();

      repeat (40) @(posedge clock);
      $display("covered store, opening-add, find and the unused op over table sizes 0..2047,");
      $display("%0d requests taken, %0d responses checked, %0d finds hit, %0d mismatches",
               requests_taken, responses_checked, finds_hit, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
